### hdl/sts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam logic [4:0] K_EOF   = 5'd0;
  localparam logic [4:0] K_NL    = 5'd1;
  localparam logic [4:0] K_PLUS  = 5'd2;
  localparam logic [4:0] K_MINUS = 5'd3;
  localparam logic [4:0] K_STAR  = 5'd4;
  localparam logic [4:0] K_SLASH = 5'd5;
  localparam logic [4:0] K_LPAR  = 5'd6;
  localparam logic [4:0] K_RPAR  = 5'd7;
  localparam logic [4:0] K_OPQ   = 5'd8;
  localparam logic [4:0] K_LBRC  = 5'd9;
  localparam logic [4:0] K_RBRC  = 5'd10;
  localparam logic [4:0] K_GT    = 5'd11;
  localparam logic [4:0] K_GE    = 5'd12;
  localparam logic [4:0] K_LT    = 5'd13;
  localparam logic [4:0] K_LE    = 5'd14;
  localparam logic [4:0] K_BANG  = 5'd15;
  localparam logic [4:0] K_EQ    = 5'd16;
  localparam logic [4:0] K_COMMA = 5'd17;
  localparam logic [4:0] K_STR   = 5'd18;
  localparam logic [4:0] K_NUM   = 5'd19;
  localparam logic [4:0] K_IDENT = 5'd20;
  localparam logic [4:0] K_TRUE  = 5'd21;
  localparam logic [4:0] K_FALSE = 5'd22;
  localparam logic [4:0] K_NIL   = 5'd23;
  localparam logic [4:0] K_AND   = 5'd24;
  localparam logic [4:0] K_OR    = 5'd25;
  localparam logic [4:0] K_VAR   = 5'd26;
  localparam logic [4:0] K_CONST = 5'd27;
  localparam logic [4:0] K_ERR   = 5'd28;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } sts_result_t;

  typedef struct packed {
    logic [1:0]  count;
    sts_result_t first;
    sts_result_t second;
  } sts_push_t;

endpackage

`default_nettype wire

### hdl/sts_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module sts_scan #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic [7:0]       ch,
  output sts_pkg::sts_push_t    push
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_BQ     = 8'h60;
  localparam logic [7:0] CH_LBRC   = 8'h7B;
  localparam logic [7:0] CH_RBRC   = 8'h7D;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [15:0] PFX_LEN = 16'd5;

  typedef enum logic [7:0] {
    M_IDLE = 8'b0000_0001,
    M_GT   = 8'b0000_0010,
    M_LT   = 8'b0000_0100,
    M_BQ   = 8'b0000_1000,
    M_STR  = 8'b0001_0000,
    M_INT  = 8'b0010_0000,
    M_FRAC = 8'b0100_0000,
    M_WORD = 8'b1000_0000
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, line_inc;
  logic [39:0]            prefix_r, prefix_nxt, prefix_grow;
  logic [15:0]            wlen_r, wlen_nxt, wlen_inc;

  logic                   ea, eb, taken;
  logic [4:0]             ka, kb, ksingle, kword;
  logic [15:0]            la, lb;
  logic [LINE_BITS-1:0]   lna, lnb;
  logic [OFFSET_BITS+15:0] begin_ext, pos_ext;
  logic [LINE_BITS+15:0]  lna_ext, lnb_ext;
  logic                   is_digit, is_alpha;
  sts_pkg::sts_result_t   ra, rb;

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A)) ||
                    (ch == CH_US) || (ch == CH_AT) || (ch == CH_DOLLAR);

  assign pos_inc     = (&pos_r) ? pos_r : pos_r + OFFSET_BITS'(1);
  assign line_inc    = ((ch == CH_LF) && !(&line_r)) ? line_r + LINE_BITS'(1) : line_r;
  assign wlen_inc    = (wlen_r == LEN_MAX) ? wlen_r : wlen_r + 16'd1;
  assign prefix_grow = (wlen_r < PFX_LEN) ? {prefix_r[31:0], ch} : prefix_r;

  always_comb begin
    case (ch)
      CH_PLUS:  ksingle = sts_pkg::K_PLUS;
      CH_MINUS: ksingle = sts_pkg::K_MINUS;
      CH_STAR:  ksingle = sts_pkg::K_STAR;
      CH_SLASH: ksingle = sts_pkg::K_SLASH;
      CH_LPAR:  ksingle = sts_pkg::K_LPAR;
      CH_RPAR:  ksingle = sts_pkg::K_RPAR;
      CH_LBRC:  ksingle = sts_pkg::K_LBRC;
      CH_RBRC:  ksingle = sts_pkg::K_RBRC;
      CH_BANG:  ksingle = sts_pkg::K_BANG;
      CH_EQ:    ksingle = sts_pkg::K_EQ;
      CH_COMMA: ksingle = sts_pkg::K_COMMA;
      default:  ksingle = sts_pkg::K_EOF;
    endcase
  end

  always_comb begin
    if ((wlen_r == 16'd4) && (prefix_r == 40'h0074727565)) begin
      kword = sts_pkg::K_TRUE;
    end else if ((wlen_r == 16'd5) && (prefix_r == 40'h66616C7365)) begin
      kword = sts_pkg::K_FALSE;
    end else if ((wlen_r == 16'd3) && (prefix_r == 40'h00006E696C)) begin
      kword = sts_pkg::K_NIL;
    end else if ((wlen_r == 16'd3) && (prefix_r == 40'h0000616E64)) begin
      kword = sts_pkg::K_AND;
    end else if ((wlen_r == 16'd2) && (prefix_r == 40'h0000006F72)) begin
      kword = sts_pkg::K_OR;
    end else if ((wlen_r == 16'd3) && (prefix_r == 40'h0000766172)) begin
      kword = sts_pkg::K_VAR;
    end else if ((wlen_r == 16'd5) && (prefix_r == 40'h636F6E7374)) begin
      kword = sts_pkg::K_CONST;
    end else begin
      kword = sts_pkg::K_IDENT;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    begin_nxt  = begin_r;
    line_nxt   = line_r;
    prefix_nxt = prefix_r;
    wlen_nxt   = wlen_r;
    ea         = 1'b0;
    ka         = sts_pkg::K_EOF;
    la         = wlen_r;
    lna        = line_r;
    taken      = 1'b0;
    eb         = 1'b0;
    kb         = sts_pkg::K_EOF;
    lb         = 16'd1;
    lnb        = line_r;

    // close or extend the held token
    case (mode_r)
      M_GT, M_LT: begin
        ea       = 1'b1;
        mode_nxt = M_IDLE;
        if (ch == CH_EQ) begin
          taken    = 1'b1;
          ka       = (mode_r == M_GT) ? sts_pkg::K_GE : sts_pkg::K_LE;
          la       = wlen_inc;
          lna      = line_inc;
          pos_nxt  = pos_inc;
          line_nxt = line_inc;
        end else begin
          ka = (mode_r == M_GT) ? sts_pkg::K_GT : sts_pkg::K_LT;
        end
      end
      M_BQ: begin
        ea       = 1'b1;
        mode_nxt = M_IDLE;
        if (ch == CH_LPAR) begin
          taken    = 1'b1;
          ka       = sts_pkg::K_OPQ;
          la       = wlen_inc;
          lna      = line_inc;
          pos_nxt  = pos_inc;
          line_nxt = line_inc;
        end else begin
          ka = sts_pkg::K_ERR;
        end
      end
      M_STR: begin
        if (ch == CH_NUL) begin
          ea       = 1'b1;
          ka       = sts_pkg::K_ERR;
          mode_nxt = M_IDLE;
        end else begin
          taken      = 1'b1;
          prefix_nxt = prefix_grow;
          wlen_nxt   = wlen_inc;
          pos_nxt    = pos_inc;
          line_nxt   = line_inc;
          if (ch == CH_QUOTE) begin
            ea       = 1'b1;
            ka       = sts_pkg::K_STR;
            la       = wlen_inc;
            lna      = line_inc;
            mode_nxt = M_IDLE;
          end
        end
      end
      M_INT, M_FRAC: begin
        if (is_digit || ((ch == CH_DOT) && (mode_r == M_INT))) begin
          taken      = 1'b1;
          prefix_nxt = prefix_grow;
          wlen_nxt   = wlen_inc;
          pos_nxt    = pos_inc;
          line_nxt   = line_inc;
          if (ch == CH_DOT) begin
            mode_nxt = M_FRAC;
          end
        end else begin
          ea       = 1'b1;
          ka       = sts_pkg::K_NUM;
          mode_nxt = M_IDLE;
        end
      end
      M_WORD: begin
        if (is_alpha || is_digit) begin
          taken      = 1'b1;
          prefix_nxt = prefix_grow;
          wlen_nxt   = wlen_inc;
          pos_nxt    = pos_inc;
          line_nxt   = line_inc;
        end else begin
          ea       = 1'b1;
          ka       = kword;
          mode_nxt = M_IDLE;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    // scan the byte as the start of a new token
    if (!taken) begin
      if (ch == CH_NUL) begin
        eb         = 1'b1;
        kb         = sts_pkg::K_EOF;
        lb         = 16'd0;
        mode_nxt   = M_IDLE;
        pos_nxt    = '0;
        begin_nxt  = '0;
        line_nxt   = LINE_BITS'(1);
        prefix_nxt = '0;
        wlen_nxt   = '0;
      end else if ((ch == CH_SP) || (ch == CH_TAB) || (ch == CH_CR)) begin
        pos_nxt = pos_inc;
      end else if (ch == CH_LF) begin
        eb       = 1'b1;
        kb       = sts_pkg::K_NL;
        lnb      = line_inc;
        pos_nxt  = pos_inc;
        line_nxt = line_inc;
      end else if (ksingle != sts_pkg::K_EOF) begin
        eb      = 1'b1;
        kb      = ksingle;
        pos_nxt = pos_inc;
      end else if ((ch == CH_GT) || (ch == CH_LT) || (ch == CH_BQ) || (ch == CH_QUOTE) ||
                   is_digit || is_alpha) begin
        if (ch == CH_GT) begin
          mode_nxt = M_GT;
        end else if (ch == CH_LT) begin
          mode_nxt = M_LT;
        end else if (ch == CH_BQ) begin
          mode_nxt = M_BQ;
        end else if (ch == CH_QUOTE) begin
          mode_nxt = M_STR;
        end else if (is_digit) begin
          mode_nxt = M_INT;
        end else begin
          mode_nxt = M_WORD;
        end
        begin_nxt  = pos_r;
        prefix_nxt = {32'd0, ch};
        wlen_nxt   = 16'd1;
        pos_nxt    = pos_inc;
      end else begin
        eb      = 1'b1;
        kb      = sts_pkg::K_ERR;
        pos_nxt = pos_inc;
      end
    end
  end

  assign begin_ext = {16'd0, begin_r};
  assign pos_ext   = {16'd0, pos_r};
  assign lna_ext   = {16'd0, lna};
  assign lnb_ext   = {16'd0, lnb};

  always_comb begin
    ra.kind  = ka;
    ra.start = begin_ext[15:0];
    ra.len   = la;
    ra.line  = lna_ext[15:0];
    ra.last  = !eb;
    rb.kind  = kb;
    rb.start = pos_ext[15:0];
    rb.len   = lb;
    rb.line  = lnb_ext[15:0];
    rb.last  = 1'b1;
    push.count  = {1'b0, ea} + {1'b0, eb};
    push.first  = ea ? ra : rb;
    push.second = rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      begin_r  <= '0;
      line_r   <= LINE_BITS'(1);
      prefix_r <= '0;
      wlen_r   <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
      line_r   <= line_nxt;
      prefix_r <= prefix_nxt;
      wlen_r   <= wlen_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sts_rq.sv
`timescale 1ns / 1ps
`default_nettype none

module sts_rq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  sts_pkg::sts_push_t        push,
  input  wire logic                 pop,
  output sts_pkg::sts_result_t      head,
  output logic                      not_empty,
  output logic                      room
);

  sts_pkg::sts_result_t             mem_r [sts_pkg::RQ_DEPTH];
  logic [sts_pkg::RQ_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [sts_pkg::RQ_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sts_pkg::RQ_PTR_W:0]       count_r, count_nxt;
  logic [1:0]                       n_wr;
  logic                             do_pop;

  assign n_wr      = wr_en ? push.count : 2'd0;
  assign do_pop    = pop && not_empty;
  assign wr_ptr_p1 = wr_ptr_r + sts_pkg::RQ_PTR_W'(1);
  assign not_empty = (count_r != '0);
  assign room      = (count_r <= (sts_pkg::RQ_PTR_W + 1)'(sts_pkg::RQ_DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + sts_pkg::RQ_PTR_W'(n_wr);
    rd_ptr_nxt = do_pop ? rd_ptr_r + sts_pkg::RQ_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (sts_pkg::RQ_PTR_W + 1)'(n_wr) -
                 (sts_pkg::RQ_PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (n_wr == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

endmodule

`default_nettype wire

### hdl/source_token_scanner_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Source token scanner.
// Input: one source byte per word on in_ch, valid/ready handshake; a zero
// byte ends the source and resets the scanner for the next one.
// Output: one token per word (kind, start offset, length, line after the
// token, last flag), valid/ready handshake. A byte yields zero, one or two
// tokens; out_last marks the final token caused by that byte.
// Output path: each token is written into the result queue when the byte
// that completes it is accepted, and is shown from the queue head.
// Throughput: one byte per cycle unless stalled, set by the single scan
// stage; two tokens from one byte are absorbed by a four-entry result
// queue. in_ready is high while the queue has room for two tokens.
// Stall: when out_ready is low, tokens wait in the queue and in_ready drops
// once fewer than two entries are free; nothing is lost.
// Reset: a synchronous rst_n low empties the queue and returns the scanner
// to offset 0, line 1, between tokens.
module source_token_scanner_top #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_start_offset,
  output logic [15:0]      out_token_len,
  output logic [15:0]      out_line_no,
  output logic             out_last
);

  sts_pkg::sts_push_t   push;
  sts_pkg::sts_result_t head;
  logic                 acc;
  logic                 room;

  assign in_ready = room;
  assign acc      = in_valid && room;

  sts_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_ch),
    .push  (push)
  );

  sts_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (acc),
    .push      (push),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  assign out_token_kind   = head.kind;
  assign out_start_offset = head.start;
  assign out_token_len    = head.len;
  assign out_line_no      = head.line;
  assign out_last         = head.last;

endmodule

`default_nettype wire

### hdl/sts_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  out_token_kind,
  input wire logic [15:0] out_start_offset,
  input wire logic [15:0] out_token_len,
  input wire logic [15:0] out_line_no,
  input wire logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the word was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_token_kind) && $stable(out_start_offset) &&
      $stable(out_token_len) && $stable(out_line_no) && $stable(out_last))
    else $error("output word changed while stalled");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == sts_pkg::K_EOF) |-> out_last && (out_token_len == 16'd0))
    else $error("eof token not final or not empty");

  a_nl_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == sts_pkg::K_NL) |-> (out_token_len == 16'd1) && out_last)
    else $error("newline token malformed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_kind <= sts_pkg::K_ERR))
    else $error("token kind out of range");

endmodule

bind source_token_scanner_top sts_checker u_sts_checker (.*);

`default_nettype wire

### tb/source_token_scanner_top_tb.sv
`timescale 1ns / 1ps

module source_token_scanner_top_tb;

  localparam logic [7:0] CH_EOS   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_BQ    = 8'h60;
  localparam int         RANDOM_BYTES = 2000;

  typedef enum logic [7:0] {
    SC_IDLE = 8'b0000_0001,
    SC_GT   = 8'b0000_0010,
    SC_LT   = 8'b0000_0100,
    SC_BQ   = 8'b0000_1000,
    SC_STR  = 8'b0001_0000,
    SC_INT  = 8'b0010_0000,
    SC_FRAC = 8'b0100_0000,
    SC_WORD = 8'b1000_0000
  } scan_state_t;

  typedef struct packed {
    logic [7:0]           ch;
    logic                 typed;
    sts_pkg::sts_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_token_kind;
  logic [15:0] out_start_offset;
  logic [15:0] out_token_len;
  logic [15:0] out_line_no;
  logic        out_last;

  sts_pkg::sts_result_t pending_tokens[$];
  int          mismatches;
  int          bytes_sent;
  int          last_added;
  bit          steady;

  scan_state_t sc_mode;
  logic [15:0] sc_pos;
  logic [15:0] sc_begin;
  logic [15:0] sc_line;
  logic [15:0] sc_len;
  logic [39:0] sc_prefix;

  string keywords [7] = '{"true", "false", "nil", "and", "or", "var", "const"};
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_@$0123456789";
  string op_chars = "+-*/(){}!=,";
  logic [7:0] blanks [4] = '{8'h20, CH_TAB, CH_CR, CH_NL};

  stim_row_t plan [26] = '{
    '{"+",      1'b1, '{sts_pkg::K_PLUS,  0, 1, 1, 1'b1}},
    '{CH_NL,    1'b1, '{sts_pkg::K_NL,    1, 1, 2, 1'b1}},
    '{">",      1'b0, '0},
    '{"=",      1'b1, '{sts_pkg::K_GE,    2, 2, 2, 1'b1}},
    '{"<",      1'b0, '0},
    '{"x",      1'b0, '0},
    '{8'h20,    1'b0, '0},
    '{CH_BQ,    1'b0, '0},
    '{"(",      1'b1, '{sts_pkg::K_OPQ,   7, 2, 2, 1'b1}},
    '{CH_BQ,    1'b0, '0},
    '{"a",      1'b0, '0},
    '{",",      1'b0, '0},
    '{8'hFF,    1'b1, '{sts_pkg::K_ERR,  12, 1, 2, 1'b1}},
    '{"1",      1'b0, '0},
    '{".",      1'b0, '0},
    '{"5",      1'b0, '0},
    '{".",      1'b0, '0},
    '{CH_QUOTE, 1'b0, '0},
    '{CH_NL,    1'b0, '0},
    '{CH_EOS,   1'b0, '0},
    '{CH_TAB,   1'b0, '0},
    '{CH_CR,    1'b0, '0},
    '{"o",      1'b0, '0},
    '{"r",      1'b0, '0},
    '{"*",      1'b0, '0},
    '{CH_EOS,   1'b1, '{sts_pkg::K_EOF,   5, 0, 1, 1'b1}}
  };

  source_token_scanner_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_token_len    (out_token_len),
    .out_line_no      (out_line_no),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           b == "_" || b == "@" || b == "$";
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] b);
    case (b)
      "+": return sts_pkg::K_PLUS;
      "-": return sts_pkg::K_MINUS;
      "*": return sts_pkg::K_STAR;
      "/": return sts_pkg::K_SLASH;
      "(": return sts_pkg::K_LPAR;
      ")": return sts_pkg::K_RPAR;
      "{": return sts_pkg::K_LBRC;
      "}": return sts_pkg::K_RBRC;
      "!": return sts_pkg::K_BANG;
      "=": return sts_pkg::K_EQ;
      ",": return sts_pkg::K_COMMA;
      default: return sts_pkg::K_EOF;
    endcase
  endfunction

  function automatic void clear_scanner();
    sc_mode   = SC_IDLE;
    sc_pos    = 16'd0;
    sc_begin  = 16'd0;
    sc_line   = 16'd1;
    sc_len    = 16'd0;
    sc_prefix = 40'd0;
  endfunction

  function automatic void take(input logic [7:0] b);
    if (b == CH_NL && sc_line != 16'hFFFF) sc_line++;
    if (sc_pos != 16'hFFFF) sc_pos++;
  endfunction

  function automatic void grow(input logic [7:0] b);
    if (sc_len < 16'd5) sc_prefix = {sc_prefix[31:0], b};
    if (sc_len != 16'hFFFF) sc_len++;
  endfunction

  function automatic void open_token(input scan_state_t mode, input logic [7:0] b);
    sc_mode   = mode;
    sc_begin  = sc_pos;
    sc_prefix = 40'd0;
    sc_len    = 16'd0;
    grow(b);
  endfunction

  function automatic void add_token(input logic [4:0] kind, input logic [15:0] start,
                                    input logic [15:0] len);
    sts_pkg::sts_result_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = sc_line;
    t.last  = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  function automatic void close_token(input logic [4:0] kind);
    add_token(kind, sc_begin, sc_len);
    sc_mode = SC_IDLE;
  endfunction

  function automatic logic [4:0] keyword_of();
    if (sc_len == 16'd4 && sc_prefix == "true")  return sts_pkg::K_TRUE;
    if (sc_len == 16'd5 && sc_prefix == "false") return sts_pkg::K_FALSE;
    if (sc_len == 16'd3 && sc_prefix == "nil")   return sts_pkg::K_NIL;
    if (sc_len == 16'd3 && sc_prefix == "and")   return sts_pkg::K_AND;
    if (sc_len == 16'd2 && sc_prefix == "or")    return sts_pkg::K_OR;
    if (sc_len == 16'd3 && sc_prefix == "var")   return sts_pkg::K_VAR;
    if (sc_len == 16'd5 && sc_prefix == "const") return sts_pkg::K_CONST;
    return sts_pkg::K_IDENT;
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    int                   n0;
    bit                   taken;
    logic [4:0]           op;
    logic [15:0]          at;
    scan_state_t          mode;
    sts_pkg::sts_result_t t;
    n0    = pending_tokens.size();
    taken = 1'b0;
    op    = op_kind(b);
    case (sc_mode)
      SC_GT, SC_LT: begin
        if (b == "=") begin
          grow(b);
          take(b);
          close_token(sc_mode == SC_GT ? sts_pkg::K_GE : sts_pkg::K_LE);
          taken = 1'b1;
        end else begin
          close_token(sc_mode == SC_GT ? sts_pkg::K_GT : sts_pkg::K_LT);
        end
      end
      SC_BQ: begin
        if (b == "(") begin
          grow(b);
          take(b);
          close_token(sts_pkg::K_OPQ);
          taken = 1'b1;
        end else begin
          close_token(sts_pkg::K_ERR);
        end
      end
      SC_STR: begin
        if (b == CH_EOS) begin
          close_token(sts_pkg::K_ERR);
        end else begin
          grow(b);
          take(b);
          if (b == CH_QUOTE) close_token(sts_pkg::K_STR);
          taken = 1'b1;
        end
      end
      SC_INT, SC_FRAC: begin
        if (is_digit(b) || (b == "." && sc_mode == SC_INT)) begin
          if (b == ".") sc_mode = SC_FRAC;
          grow(b);
          take(b);
          taken = 1'b1;
        end else begin
          close_token(sts_pkg::K_NUM);
        end
      end
      SC_WORD: begin
        if (is_alpha(b) || is_digit(b)) begin
          grow(b);
          take(b);
          taken = 1'b1;
        end else begin
          close_token(keyword_of());
        end
      end
      default: sc_mode = SC_IDLE;
    endcase
    if (!taken) begin
      at = sc_pos;
      if (b == CH_EOS) begin
        add_token(sts_pkg::K_EOF, sc_pos, 16'd0);
        clear_scanner();
      end else if (b == 8'h20 || b == CH_TAB || b == CH_CR) begin
        take(b);
      end else if (b == CH_NL) begin
        take(b);
        add_token(sts_pkg::K_NL, at, 16'd1);
      end else if (op != sts_pkg::K_EOF) begin
        take(b);
        add_token(op, at, 16'd1);
      end else if (b == ">" || b == "<" || b == CH_BQ || b == CH_QUOTE ||
                   is_digit(b) || is_alpha(b)) begin
        if (b == ">") mode = SC_GT;
        else if (b == "<") mode = SC_LT;
        else if (b == CH_BQ) mode = SC_BQ;
        else if (b == CH_QUOTE) mode = SC_STR;
        else if (is_digit(b)) mode = SC_INT;
        else mode = SC_WORD;
        open_token(mode, b);
        take(b);
      end else begin
        take(b);
        add_token(sts_pkg::K_ERR, at, 16'd1);
      end
    end
    last_added = pending_tokens.size() - n0;
    if (pending_tokens.size() > n0) begin
      t = pending_tokens.pop_back();
      t.last = 1'b1;
      pending_tokens.push_back(t);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    sts_pkg::sts_result_t want;
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 27);
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d start %0d",
                                  out_token_kind, out_start_offset));
      end else begin
        want = pending_tokens.pop_front();
        if (out_token_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_token_kind, want.kind));
        if (out_start_offset !== want.start)
          report_mismatch($sformatf("start %0d, want %0d", out_start_offset, want.start));
        if (out_token_len !== want.len)
          report_mismatch($sformatf("len %0d, want %0d", out_token_len, want.len));
        if (out_line_no !== want.line)
          report_mismatch($sformatf("line %0d, want %0d", out_line_no, want.line));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic send_phrase();
    string w;
    int    pick;
    int    n;
    pick = $urandom_range(99);
    if (pick < 20) begin
      w = keywords[$urandom_range(6)];
      n = $urandom_range(9);
      if (n == 0) w = w.substr(0, w.len() - 2);
      send_text(w);
      if (n == 1) send_byte(word_chars[$urandom_range(64)]);
    end else if (pick < 35) begin
      send_byte(word_chars[$urandom_range(54)]);
      repeat ($urandom_range(6)) send_byte(word_chars[$urandom_range(64)]);
    end else if (pick < 50) begin
      repeat ($urandom_range(1, 4)) send_byte(8'h30 + 8'($urandom_range(9)));
      if ($urandom_range(1) == 1) begin
        send_byte(".");
        repeat ($urandom_range(3)) send_byte(8'h30 + 8'($urandom_range(9)));
        if ($urandom_range(9) == 0) send_byte(".");
      end
    end else if (pick < 60) begin
      send_byte(CH_QUOTE);
      repeat ($urandom_range(6))
        send_byte($urandom_range(3) == 0 ? CH_NL : 8'($urandom_range(32, 126)));
      if ($urandom_range(9) != 0) send_byte(CH_QUOTE);
    end else if (pick < 75) begin
      n = $urandom_range(16);
      if (n < 11) begin
        send_byte(op_chars[n]);
      end else begin
        case (n)
          11: send_byte(">");
          12: send_text(">=");
          13: send_byte("<");
          14: send_text("<=");
          15: begin
            send_byte(CH_BQ);
            send_byte("(");
          end
          default: send_byte(CH_BQ);
        endcase
      end
    end else if (pick < 87) begin
      send_byte(blanks[$urandom_range(3)]);
    end else if (pick < 95) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(CH_EOS);
    end
  endtask

  initial begin
    int base;
    int next_hold;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_ch      = 8'h00;
    steady     = 1'b0;
    mismatches = 0;
    bytes_sent = 0;
    last_added = 0;
    clear_scanner();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      send_byte(plan[i].ch);
      if (plan[i].typed) begin
        repeat (last_added) void'(pending_tokens.pop_back());
        pending_tokens.push_back(plan[i].want);
      end
    end
    hold_until_drained();

    base      = bytes_sent;
    next_hold = 500;
    while (bytes_sent - base < RANDOM_BYTES) begin
      steady = (bytes_sent - base >= 700) && (bytes_sent - base < 1100);
      send_phrase();
      if (bytes_sent - base >= next_hold) begin
        hold_until_drained();
        next_hold += 500;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("source_token_scanner_top_tb: clean");
    else $display("source_token_scanner_top_tb: errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("source_token_scanner_top_tb: errors");
    $finish;
  end

endmodule
